FILE: rtl/mdsc_pkg.sv
// ---------------------------------------------------------------------------
// mdsc_pkg
// Shared types and codes for the method descriptor slot counter.
// ---------------------------------------------------------------------------
package mdsc_pkg;

    // parser phase codes
    localparam logic [2:0] PH_BEFORE_OPEN = 3'd0;
    localparam logic [2:0] PH_IN_LIST     = 3'd1;
    localparam logic [2:0] PH_OBJ_SKIP    = 3'd2;
    localparam logic [2:0] PH_OBJ_NAME    = 3'd3;
    localparam logic [2:0] PH_ARRAY       = 3'd4;
    localparam logic [2:0] PH_ARRAY_NAME  = 3'd5;
    localparam logic [2:0] PH_CLOSED      = 3'd6;

    // sticky error flag bit positions
    localparam int unsigned ERR_BAD_BIT = 0;
    localparam int unsigned ERR_SAT_BIT = 1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_ELEM   = 2'd1;
    localparam logic [1:0] ST_NOT_CLOSED = 2'd2;
    localparam logic [1:0] ST_SATURATED  = 2'd3;

    // descriptor characters
    localparam logic [7:0] CH_OPEN  = 8'h28;  // (
    localparam logic [7:0] CH_CLOSE = 8'h29;  // )
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
    localparam logic [7:0] CH_ARR   = 8'h5B;  // [
    localparam logic [7:0] CH_OBJ   = 8'h4C;  // L
    localparam logic [7:0] CH_LONG  = 8'h4A;  // J
    localparam logic [7:0] CH_DBL   = 8'h44;  // D
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_V     = 8'h56;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] count;
        logic [1:0] err;
        logic       first;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_BEFORE_OPEN,
        count: 8'd0,
        err:   2'b00,
        first: 1'b1
    };

endpackage

FILE: rtl/mdsc_step.sv
// ---------------------------------------------------------------------------
// mdsc_step
// One-byte parser update: next state and the result fields for a last byte.
// ---------------------------------------------------------------------------
module mdsc_step
    import mdsc_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_static,
    input  logic       i_last_byte,
    output t_state     o_state,
    output logic [7:0] o_slot_count,
    output logic [1:0] o_status
);

    logic [7:0] base_count;
    logic [1:0] add_n;
    logic [8:0] sum;
    logic [2:0] ph;
    logic [1:0] err;
    logic [7:0] cnt;

    always_comb begin
        base_count = i_state.first ? {7'd0, ~i_is_static} : i_state.count;
        ph         = i_state.phase;
        err        = i_state.err;
        add_n      = 2'd0;

        case (i_state.phase)
            PH_BEFORE_OPEN: begin
                if (i_char_byte == CH_OPEN) ph = PH_IN_LIST;
            end
            PH_IN_LIST: begin
                if (i_char_byte inside {CH_B, CH_C, CH_S, CH_F, CH_I, CH_Z, CH_V}) begin
                    add_n = 2'd1;
                end else if (i_char_byte inside {CH_LONG, CH_DBL}) begin
                    add_n = 2'd2;
                end else if (i_char_byte == CH_OBJ) begin
                    add_n = 2'd1;
                    ph    = PH_OBJ_SKIP;
                end else if (i_char_byte == CH_ARR) begin
                    add_n = 2'd1;
                    ph    = PH_ARRAY;
                end else if (i_char_byte == CH_CLOSE) begin
                    ph = PH_CLOSED;
                end else begin
                    err[ERR_BAD_BIT] = 1'b1;
                    ph               = PH_CLOSED;
                end
            end
            PH_OBJ_SKIP: begin
                ph = PH_OBJ_NAME;
            end
            PH_OBJ_NAME, PH_ARRAY_NAME: begin
                if (i_char_byte == CH_SEMI) ph = PH_IN_LIST;
            end
            PH_ARRAY: begin
                if (i_char_byte == CH_OBJ) begin
                    ph = PH_ARRAY_NAME;
                end else if (i_char_byte != CH_ARR) begin
                    ph = PH_IN_LIST;
                end
            end
            default: begin
            end
        endcase

        // saturating add
        sum = {1'b0, base_count} + {7'd0, add_n};
        if (sum[8]) begin
            cnt              = 8'hFF;
            err[ERR_SAT_BIT] = 1'b1;
        end else begin
            cnt = sum[7:0];
        end

        if (err[ERR_BAD_BIT]) begin
            o_status = ST_BAD_ELEM;
        end else if (ph != PH_CLOSED) begin
            o_status = ST_NOT_CLOSED;
        end else if (err[ERR_SAT_BIT]) begin
            o_status = ST_SATURATED;
        end else begin
            o_status = ST_OK;
        end
        o_slot_count = cnt;

        if (i_last_byte) begin
            o_state = STATE_RESET;
        end else begin
            o_state.phase = ph;
            o_state.count = cnt;
            o_state.err   = err;
            o_state.first = 1'b0;
        end
    end

endmodule

FILE: rtl/method_descriptor_slot_counter_unit.sv
// ---------------------------------------------------------------------------
// method_descriptor_slot_counter_unit
// Counts JVM argument slots of a method descriptor streamed one byte a cycle when not stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one descriptor byte per
//   transaction with i_is_static (sampled on the first byte) and
//   i_last_byte marking the end of the descriptor.
//   Output channel (o_valid / i_ready) carries one transaction per
//   descriptor: o_slot_count (saturating at 255) and o_status
//   (ok, bad element byte, list not closed, count saturated).
//   Bytes without i_last_byte produce no output transaction.
// Path: a byte is captured in the input register and parsed from there
//   straight into the output register; with a free output register,
//   o_valid rises once the last byte has passed through the input
//   register and the output register.
// Throughput: one byte per cycle unless stalled. The parser state update is a
//   single short step between the input register and the state register.
// Stall: while the output register holds an untaken result, a new last byte
//   waits in the input register; other bytes keep flowing. o_ready drops
//   only when the input register is full and cannot advance.
// Reset: synchronous active-low i_rst_n empties both registers and puts the
//   parser in its start state (before '(' with the first-byte flag set).
// ---------------------------------------------------------------------------
module method_descriptor_slot_counter_unit
    import mdsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_static,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_slot_count,
    output logic [1:0] o_status
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_static;
    logic       r_in_last;

    // parser state
    t_state     r_state;
    t_state     n_state;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_count;
    logic [1:0] r_out_status;
    logic [7:0] n_out_count;
    logic [1:0] n_out_status;

    logic out_free;
    logic fire;

    // a last byte may only be parsed when the output register can take it
    assign out_free = !r_out_vld || i_ready;
    assign fire     = r_in_vld && (!r_in_last || out_free);
    assign o_ready  = !r_in_vld || fire;

    mdsc_step u_step (
        .i_state      (r_state),
        .i_char_byte  (r_in_char),
        .i_is_static  (r_in_static),
        .i_last_byte  (r_in_last),
        .o_state      (n_state),
        .o_slot_count (n_out_count),
        .o_status     (n_out_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char   <= i_char_byte;
            r_in_static <= i_is_static;
            r_in_last   <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out_count  <= n_out_count;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_slot_count = r_out_count;
    assign o_status     = r_out_status;

`ifndef NO_ASSERTIONS
    // a last byte is never parsed over an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |-> out_free)
        else $error("result register overwritten");

    // the parser restarts after every descriptor and the result is posted
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_state.first && r_out_vld)
        else $error("parser did not restart after last byte");

    // the saturation flag only stands with a pinned count
    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err[ERR_SAT_BIT] |-> r_state.count == 8'hFF)
        else $error("saturation flag without full count");
`endif

endmodule
